// ===== design/pgwalk_pkg.sv =====
// Package for the four-level page table walker: sequencer states, command and
// status codes, entry bit positions and the default store size.
// No dependencies.
package pgwalk_pkg;

    localparam int unsigned TABLE_FRAMES_DEF = 64;

    localparam int unsigned ENT_IDX_W   = 9;
    localparam int unsigned FRAME_NUM_W = 40;

    localparam int unsigned BIT_PRESENT = 0;
    localparam int unsigned BIT_LARGE   = 7;

    localparam logic [1:0] CMD_TRANSLATE = 2'd0;
    localparam logic [1:0] CMD_MAP       = 2'd1;
    localparam logic [1:0] CMD_UNMAP     = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_UNMAPPED = 3'd1;
    localparam logic [2:0] ST_LARGE    = 3'd2;
    localparam logic [2:0] ST_NOFRAME  = 3'd3;
    localparam logic [2:0] ST_OUTSIDE  = 3'd4;

    // Level codes: 3..1 are the upper levels (PML4, PDPT, PD), 0 the leaf table
    localparam logic [1:0] LVL_TOP  = 2'd3;
    localparam logic [1:0] LVL_LEAF = 2'd0;

    localparam logic [11:0] NEW_TABLE_FLAGS = 12'h007;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CHECK,
        S_ZERO,
        S_LINK
    } walk_state_t;

endpackage

// ===== design/four_level_page_table_walker_core.sv =====
// Four-level page table walker over a local table store held in block memory.
// Depends on pgwalk_pkg for states, codes and the default store size.
//
// Each level takes a read state and a check state; a new command is accepted
// only in the idle state, so not before the last result. Each new table adds a
// wipe of its frame through the single memory port plus a link write. Unknown
// commands answer straight from the idle state. busy is high while a walk runs.
// After reset the store is wiped with busy high; configuration writes are taken
// throughout. The done strobe lasts one cycle and the receiver cannot stall.
module four_level_page_table_walker_core #(
    parameter int unsigned TABLE_FRAMES = pgwalk_pkg::TABLE_FRAMES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [47:0] virt_addr,
    input  logic [51:0] phys_addr,
    input  logic [63:0] entry_flags,
    input  logic        cfg_we,
    input  logic [51:0] cfg_wdata,
    output logic        done,
    output logic [2:0]  status,
    output logic [51:0] phys_result,
    output logic        tlb_flush
);
    import pgwalk_pkg::*;

    localparam int unsigned FW    = (TABLE_FRAMES > 1) ? $clog2(TABLE_FRAMES) : 1;
    localparam int unsigned NW    = $clog2(TABLE_FRAMES + 1);
    localparam int unsigned DEPTH = TABLE_FRAMES * (1 << ENT_IDX_W);
    localparam int unsigned AW    = FW + ENT_IDX_W;

    walk_state_t state_reg, state_next;

    logic [51:0]          base_reg;
    logic [NW-1:0]        nf_reg, nf_next;
    logic [FW-1:0]        cur_reg, cur_next;
    logic [1:0]           lvl_reg, lvl_next;
    logic [AW-1:0]        clr_reg, clr_next;

    logic [1:0]           cmd_reg;
    logic [47:0]          va_reg;
    logic [51:0]          pa_reg;
    logic [63:0]          flags_reg;

    logic                 done_reg, done_next;
    logic [2:0]           status_reg, status_next;
    logic [51:0]          result_reg, result_next;
    logic                 flush_reg, flush_next;

    logic [63:0]          mem [0:DEPTH-1];
    logic [63:0]          rdata_reg;
    logic                 mem_we, mem_re;
    logic [AW-1:0]        mem_addr;
    logic [63:0]          mem_wdata;

    // shared frame-number adder
    logic [FRAME_NUM_W-1:0] add_a, add_b, add_res;
    logic                   add_sub;

    logic [ENT_IDX_W-1:0] idx;
    logic [AW-1:0]        slot_addr;
    logic                 accept;

    assign accept  = start && (state_reg == S_IDLE);
    assign busy    = (state_reg != S_IDLE);
    assign add_res = add_sub ? (add_a - add_b) : (add_a + add_b);

    always_comb
    begin
        unique case (lvl_reg)
            2'd3:    idx = va_reg[47:39];
            2'd2:    idx = va_reg[38:30];
            2'd1:    idx = va_reg[29:21];
            default: idx = va_reg[20:12];
        endcase
    end

    assign slot_addr = {cur_reg, idx};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            base_reg  <= '0;
            nf_reg    <= NW'(1);
            cur_reg   <= '0;
            lvl_reg   <= LVL_TOP;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            nf_reg    <= nf_next;
            cur_reg   <= cur_next;
            lvl_reg   <= lvl_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                base_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        result_reg <= result_next;
        flush_reg  <= flush_next;
        if (accept)
        begin
            cmd_reg   <= command;
            va_reg    <= virt_addr;
            pa_reg    <= phys_addr;
            flags_reg <= entry_flags;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        nf_next     = nf_reg;
        cur_next    = cur_reg;
        lvl_next    = lvl_reg;
        clr_next    = clr_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        result_next = result_reg;
        flush_next  = flush_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = slot_addr;
        mem_wdata   = '0;
        add_a       = rdata_reg[51:12];
        add_b       = base_reg[51:12];
        add_sub     = 1'b1;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_addr = clr_reg;
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    clr_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + AW'(1);
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    cur_next = '0;
                    lvl_next = LVL_TOP;
                    if (command == CMD_TRANSLATE || command == CMD_MAP
                        || command == CMD_UNMAP)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        done_next   = 1'b1;
                        status_next = ST_UNMAPPED;
                        result_next = '0;
                        flush_next  = 1'b0;
                    end
                end
            end

            S_READ:
            begin
                mem_re     = 1'b1;
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                result_next = '0;
                flush_next  = 1'b0;
                if (lvl_reg != LVL_LEAF)
                begin
                    priority if (!rdata_reg[BIT_PRESENT])
                    begin
                        if (cmd_reg != CMD_MAP)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_UNMAPPED;
                            state_next  = S_IDLE;
                        end
                        else if (nf_reg >= NW'(TABLE_FRAMES))
                        begin
                            done_next   = 1'b1;
                            status_next = ST_NOFRAME;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            clr_next   = '0;
                            state_next = S_ZERO;
                        end
                    end
                    else if (rdata_reg[BIT_LARGE])
                    begin
                        done_next   = 1'b1;
                        status_next = ST_LARGE;
                        state_next  = S_IDLE;
                    end
                    else if (add_res >= FRAME_NUM_W'(TABLE_FRAMES))
                    begin
                        done_next   = 1'b1;
                        status_next = ST_OUTSIDE;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        // descend into the next table
                        cur_next   = add_res[FW-1:0];
                        lvl_next   = lvl_reg - 2'd1;
                        state_next = S_READ;
                    end
                end
                else
                begin
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    state_next  = S_IDLE;
                    priority if (cmd_reg == CMD_MAP)
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = {12'd0, pa_reg[51:12], 12'd0} | flags_reg | 64'd1;
                    end
                    else if (!rdata_reg[BIT_PRESENT])
                    begin
                        status_next = ST_UNMAPPED;
                    end
                    else if (cmd_reg == CMD_UNMAP)
                    begin
                        mem_we     = 1'b1;
                        mem_wdata  = '0;
                        flush_next = 1'b1;
                    end
                    else
                    begin
                        result_next = {rdata_reg[51:12], va_reg[11:0]};
                    end
                end
            end

            S_ZERO:
            begin
                // wipe the frame about to be linked in
                mem_we   = 1'b1;
                mem_addr = {nf_reg[FW-1:0], clr_reg[ENT_IDX_W-1:0]};
                if (clr_reg[ENT_IDX_W-1:0] == {ENT_IDX_W{1'b1}})
                begin
                    clr_next   = '0;
                    state_next = S_LINK;
                end
                else
                begin
                    clr_next = clr_reg + AW'(1);
                end
            end

            S_LINK:
            begin
                add_a      = base_reg[51:12];
                add_b      = FRAME_NUM_W'(nf_reg);
                add_sub    = 1'b0;
                mem_we     = 1'b1;
                mem_wdata  = {12'd0, add_res, NEW_TABLE_FLAGS};
                cur_next   = nf_reg[FW-1:0];
                nf_next    = nf_reg + NW'(1);
                lvl_next   = lvl_reg - 2'd1;
                state_next = S_READ;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign phys_result = result_reg;
    assign tlb_flush   = flush_reg;

endmodule

// ===== tb/sv/tb_four_level_page_table_walker_core.sv =====
// Self-checking bench for four_level_page_table_walker_core: a queue-fed driver, a strobe
// monitor and a shadow copy of the table store that predicts every answer.
// Depends on pgwalk_pkg and the core itself.
module tb_four_level_page_table_walker_core;
    timeunit 1ns;
    timeprecision 1ps;

    import pgwalk_pkg::*;

    localparam int unsigned N_FRAMES   = TABLE_FRAMES_DEF;
    localparam logic [1:0]  CMD_RESERVED = 2'd3;
    localparam logic [63:0] ADDR_MASK  = 64'h000F_FFFF_FFFF_F000;
    localparam logic [63:0] MASK52     = 64'h000F_FFFF_FFFF_FFFF;
    localparam int          IDLE_LIMIT = 200000;
    localparam int          POOL_MAX   = 48;

    typedef struct packed {
        logic [1:0]  op;
        logic [47:0] va;
        logic [51:0] pa;
        logic [63:0] flags;
    } walk_cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [51:0] phys;
        logic        flush;
    } walk_res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  command = '0;
    logic [47:0] virt_addr = '0;
    logic [51:0] phys_addr = '0;
    logic [63:0] entry_flags = '0;
    logic        cfg_we = 1'b0;
    logic [51:0] cfg_wdata = '0;
    logic        done;
    logic [2:0]  status;
    logic [51:0] phys_result;
    logic        tlb_flush;

    // Shadow of the block's state
    logic [63:0] pt_mem [0:N_FRAMES*512-1];
    int unsigned alloc_next;
    logic [51:0] store_base;

    walk_cmd_t   cmd_backlog [$];
    walk_res_t   walk_answers [$];
    logic [47:0] va_pool [$];

    walk_cmd_t   cur_cmd;
    walk_res_t   fresh_ans;
    walk_res_t   want;
    bit          drv_free;
    int          gap_left;
    int          burst_left;
    int          gap_roll;
    int          items_queued;
    int          results_seen;
    int          err_count;
    int          idle_cycles;

    four_level_page_table_walker_core #(
        .TABLE_FRAMES(N_FRAMES)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .command    (command),
        .virt_addr  (virt_addr),
        .phys_addr  (phys_addr),
        .entry_flags(entry_flags),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .done       (done),
        .status     (status),
        .phys_result(phys_result),
        .tlb_flush  (tlb_flush)
    );

    always #5 clk = ~clk;

    function automatic logic [47:0] va_of(logic [8:0] i4, logic [8:0] i3, logic [8:0] i2,
                                          logic [8:0] i1, logic [11:0] pg_off);
        return {i4, i3, i2, i1, pg_off};
    endfunction

    // Walk the shadow tables for one command, updating them as the block would
    task automatic walk_page_tables(input walk_cmd_t it, output walk_res_t ans);
        int unsigned cur;
        int unsigned slot;
        int          lvl;
        logic [63:0] ent;
        logic [63:0] off;
        logic [63:0] base_a;
        logic [63:0] leaf;
        bit          stopped;
        ans.status = ST_UNMAPPED;
        ans.phys   = '0;
        ans.flush  = 1'b0;
        if (it.op != CMD_RESERVED)
        begin
            ans.status = ST_OK;
            base_a  = {12'b0, store_base} & ADDR_MASK;
            cur     = 0;
            stopped = 1'b0;
            for (lvl = 4; lvl > 1; lvl--)
            begin
                if (!stopped)
                begin
                    slot = cur * 512 + it.va[12 + (lvl - 1) * 9 +: 9];
                    ent  = pt_mem[slot];
                    if (!ent[BIT_PRESENT])
                    begin
                        if (it.op != CMD_MAP)
                        begin
                            ans.status = ST_UNMAPPED;
                            stopped    = 1'b1;
                        end
                        else if (alloc_next >= N_FRAMES)
                        begin
                            ans.status = ST_NOFRAME;
                            stopped    = 1'b1;
                        end
                        else
                        begin
                            // wipe the fresh frame before linking it in
                            for (int e = 0; e < 512; e++)
                                pt_mem[alloc_next * 512 + e] = '0;
                            ent = ((base_a + (64'(alloc_next) << 12)) & ADDR_MASK)
                                  | 64'(NEW_TABLE_FLAGS);
                            pt_mem[slot] = ent;
                            alloc_next++;
                        end
                    end
                    else if (ent[BIT_LARGE])
                    begin
                        ans.status = ST_LARGE;
                        stopped    = 1'b1;
                    end
                    if (!stopped)
                    begin
                        off = ((ent & ADDR_MASK) - base_a) & MASK52;
                        if ((off >> 12) >= 64'(N_FRAMES))
                        begin
                            ans.status = ST_OUTSIDE;
                            stopped    = 1'b1;
                        end
                        else
                            cur = int'(off >> 12);
                    end
                end
            end
            if (!stopped)
            begin
                slot = cur * 512 + it.va[20:12];
                ent  = pt_mem[slot];
                if (it.op == CMD_MAP)
                begin
                    leaf = ({12'b0, it.pa} & ADDR_MASK) | it.flags;
                    leaf[BIT_PRESENT] = 1'b1;
                    pt_mem[slot] = leaf;
                end
                else if (!ent[BIT_PRESENT])
                    ans.status = ST_UNMAPPED;
                else if (it.op == CMD_UNMAP)
                begin
                    pt_mem[slot] = '0;
                    ans.flush    = 1'b1;
                end
                else
                begin
                    off = ((ent & ADDR_MASK) + 64'(it.va[11:0])) & MASK52;
                    ans.phys = off[51:0];
                end
            end
        end
    endtask

    task automatic add_cmd(logic [1:0] op, logic [47:0] va, logic [51:0] pa, logic [63:0] flags);
        walk_cmd_t it;
        it.op    = op;
        it.va    = va;
        it.pa    = pa;
        it.flags = flags;
        cmd_backlog.push_back(it);
        items_queued++;
        if (op == CMD_MAP)
        begin
            if (va_pool.size() < POOL_MAX)
                va_pool.push_back(va);
            else
                va_pool[$urandom_range(0, POOL_MAX - 1)] = va;
        end
    endtask

    // Let every outstanding walk answer, then move the store base
    task automatic set_table_base(logic [51:0] value);
        wait (results_seen == items_queued);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        store_base = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic mix_phase(int n);
        logic [63:0] r64;
        logic [47:0] va;
        logic [1:0]  op;
        logic [51:0] pa;
        logic [63:0] flags;
        int          roll;
        for (int k = 0; k < n; k++)
        begin
            roll = $urandom_range(0, 99);
            r64  = {$urandom, $urandom};
            if (va_pool.size() == 0 || roll < 8)
                va = r64[47:0];
            else
            begin
                va = va_pool[$urandom_range(0, va_pool.size() - 1)];
                // mostly stay on known paths, sometimes stray lower or higher up
                if (roll < 50)
                    va[11:0] = r64[11:0];
                else if (roll < 80)
                    va[20:0] = r64[20:0];
                else if (roll < 92)
                    va[29:0] = r64[29:0];
                else
                    va[38:0] = r64[38:0];
            end
            roll = $urandom_range(0, 99);
            if (roll < 40)
                op = CMD_MAP;
            else if (roll < 75)
                op = CMD_TRANSLATE;
            else if (roll < 94)
                op = CMD_UNMAP;
            else
                op = CMD_RESERVED;
            roll = $urandom_range(0, 99);
            r64  = {$urandom, $urandom};
            if (roll < 5)
                pa = '1;
            else if (roll < 10)
                pa = '0;
            else
                pa = r64[51:0];
            flags = {$urandom, $urandom};
            if ($urandom_range(0, 99) < 65)
                flags[51:12] = '0;
            add_cmd(op, va, pa, flags);
        end
    endtask

    // Driver: present the next pending command once the last one has transferred
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            gap_left   = 0;
            burst_left = 0;
        end
        else
        begin
            drv_free = !start;
            if (start && !busy)
            begin
                walk_page_tables(cur_cmd, fresh_ans);
                walk_answers.push_back(fresh_ans);
                drv_free = 1'b1;
            end
            if (drv_free)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (cmd_backlog.size() != 0)
                begin
                    cur_cmd      = cmd_backlog.pop_front();
                    command     <= cur_cmd.op;
                    virt_addr   <= cur_cmd.va;
                    phys_addr   <= cur_cmd.pa;
                    entry_flags <= cur_cmd.flags;
                    start       <= 1'b1;
                    gap_roll = $urandom_range(0, 99);
                    if (burst_left > 0)
                    begin
                        burst_left--;
                        gap_left = 0;
                    end
                    else if (gap_roll < 3)
                    begin
                        burst_left = $urandom_range(20, 60);
                        gap_left   = 0;
                    end
                    else if (gap_roll < 45)
                        gap_left = 0;
                    else if (gap_roll < 85)
                        gap_left = $urandom_range(1, 4);
                    else if (gap_roll < 97)
                        gap_left = $urandom_range(5, 24);
                    else
                        gap_left = $urandom_range(25, 200);
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: every done strobe is one result, matched against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (walk_answers.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got status %0d phys %h flush %b",
                         $time, status, phys_result, tlb_flush);
                err_count++;
            end
            else
            begin
                want = walk_answers.pop_front();
                if (status !== want.status)
                begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.status, status);
                    err_count++;
                end
                if (phys_result !== want.phys)
                begin
                    $display("%0t: phys_result mismatch, expected %h, got %h",
                             $time, want.phys, phys_result);
                    err_count++;
                end
                if (tlb_flush !== want.flush)
                begin
                    $display("%0t: tlb_flush mismatch, expected %b, got %b",
                             $time, want.flush, tlb_flush);
                    err_count++;
                end
                results_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        logic [51:0] base0;
        logic [51:0] phase_bases [6];
        logic [47:0] va_a;
        logic [47:0] va_b;
        logic [47:0] va_d;
        base0 = 52'h0_0001_2345_6000;
        phase_bases = '{base0, base0 - 52'h2000, 52'hF_FFFF_FFFF_FFFF, 52'h0,
                        base0 + 52'h5000, base0};
        va_a = va_of(9'h1FF, 9'h000, 9'h155, 9'h0AA, 12'hFFF);
        va_b = va_of(9'h000, 9'h000, 9'h000, 9'h000, 12'h000);
        va_d = va_of(9'h1FF, 9'h000, 9'h155, 9'h001, 12'h000);
        items_queued = 0;
        results_seen = 0;
        err_count    = 0;
        idle_cycles  = 0;
        for (int i = 0; i < N_FRAMES * 512; i++)
            pt_mem[i] = '0;
        alloc_next = 1;
        store_base = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        set_table_base(base0);
        // empty tables, reserved command
        add_cmd(CMD_TRANSLATE, va_a, '0, '0);
        add_cmd(CMD_UNMAP, va_a, '0, '0);
        add_cmd(CMD_RESERVED, '1, '1, '1);
        // full path created, leaf carries the large bit, which must be ignored
        add_cmd(CMD_MAP, va_a, '1, 64'h8000_0000_0000_0080);
        add_cmd(CMD_TRANSLATE, va_a, '0, '0);
        add_cmd(CMD_TRANSLATE, va_of(9'h1FF, 9'h000, 9'h155, 9'h0AB, 12'h000), '0, '0);
        add_cmd(CMD_MAP, va_b, '0, '0);
        add_cmd(CMD_TRANSLATE, va_of(9'h000, 9'h000, 9'h000, 9'h000, 12'hFFF), '0, '0);
        add_cmd(CMD_UNMAP, va_b, '0, '0);
        add_cmd(CMD_UNMAP, va_b, '0, '0);
        add_cmd(CMD_TRANSLATE, va_b, '0, '0);
        add_cmd(CMD_MAP, va_of(9'h1FF, 9'h000, 9'h0AA, 9'h1FF, 12'h800),
                52'h0_0000_0000_1000, 64'h0000_0000_0000_0006);
        // all-ones flags spill into the address bits: the leaf's frame reads as all ones
        add_cmd(CMD_MAP, va_d, 52'h5_A5A5_A5A5_A000, '1);
        add_cmd(CMD_TRANSLATE, va_d | 48'h123, '0, '0);

        // shift the base so the root points at a leaf table: large bit in path
        set_table_base(base0 - 52'h2000);
        add_cmd(CMD_TRANSLATE, va_of(9'h1FF, 9'h0AA, 9'h000, 9'h000, 12'h000), '0, '0);
        add_cmd(CMD_MAP, va_of(9'h1FF, 9'h0AA, 9'h003, 9'h004, 12'h000), '1, '0);
        add_cmd(CMD_TRANSLATE, va_of(9'h1FF, 9'h002, 9'h000, 9'h000, 12'h000), '0, '0);
        add_cmd(CMD_MAP, va_of(9'h1FF, 9'h002, 9'h000, 9'h000, 12'h000), 52'h0_0000_0000_7000, '0);

        // base far above every linked frame: pointers fall outside the store
        set_table_base(base0 + 52'h10_0000);
        add_cmd(CMD_TRANSLATE, va_a, '0, '0);
        add_cmd(CMD_MAP, va_a, '0, '0);
        add_cmd(CMD_MAP, va_of(9'h0F0, 9'h1FF, 9'h1FF, 9'h1FF, 12'h000), '0, 64'h2);

        set_table_base(base0);
        add_cmd(CMD_TRANSLATE, va_a, '0, '0);

        foreach (phase_bases[p])
        begin
            set_table_base(phase_bases[p]);
            mix_phase(288);
        end

        wait (results_seen == items_queued);
        repeat (20) @(posedge clk);
        if (err_count == 0 && walk_answers.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
